// ----- rtl/assert_macros.svh -----
// assertion macros shared by the decoder rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ----- rtl/tpbd_pkg.sv -----
// shared types and constants of the pattern byte decoder
// no dependencies
package tpbd_pkg;

  // default depth of the queue between decode and output
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // event codes on the result channel
  typedef enum logic [3:0] {
    EV_SAMPLE     = 4'd0,
    EV_SILENCE    = 4'd1,
    EV_NOTE       = 4'd2,
    EV_ENV_OFF    = 4'd3,
    EV_ENV_SET    = 4'd4,
    EV_ROW_END    = 4'd5,
    EV_ORNAMENT   = 4'd6,
    EV_VOLUME     = 4'd7,
    EV_TEMPO      = 4'd8,
    EV_GLIDE      = 4'd9,
    EV_GLIDE_NOTE = 4'd10,
    EV_GLIDE_OFF  = 4'd11,
    EV_NOISE      = 4'd12
  } event_kind_t;

  // classified event as handed from decode to output
  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  arg;    // byte that completed the command
    logic [7:0]  lo;     // envelope period low byte or glide step
    logic [3:0]  shape;  // envelope shape
    logic [5:0]  skip;   // skip period at the time of the event
    logic        glide;  // glide-to-note seen earlier in this row
  } tpbd_op_t;

endpackage

// ----- rtl/tpbd_if.sv -----
// request and result channel interfaces of the pattern byte decoder
// depends on nothing
interface tpbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pattern_byte;
  logic       pattern_start;

  modport source (output valid, output pattern_byte, output pattern_start, input ready);
  modport sink   (input valid, input pattern_byte, input pattern_start, output ready);
endinterface

interface tpbd_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        event_kind;
  logic signed [8:0] value_a;
  logic [15:0]       value_b;
  logic              row_end;
  logic [5:0]        empty_rows_after;

  modport source (output valid, output event_kind, output value_a, output value_b,
                  output row_end, output empty_rows_after, input ready);
  modport sink   (input valid, input event_kind, input value_a, input value_b,
                  input row_end, input empty_rows_after, output ready);
endinterface

// ----- rtl/tracker_pattern_byte_decoder_core.sv -----
// on its last byte an event is written to the queue, then to the output register
// throughput: one byte per cycle; the output register takes one queued event a cycle
// on ready; the input stalls only while the decode-to-output queue is full
// reset: synchronous active-low rst_n clears decode state, queue and output valid
// depends on tpbd_pkg, tpbd_if, tpbd_front, tpbd_queue, tpbd_back
module tracker_pattern_byte_decoder_core
  import tpbd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tpbd_in_if.sink    in_ch,
  tpbd_out_if.source out_ch
);

  logic     push, pop, q_full, q_not_empty;
  tpbd_op_t push_op, head_op;

  // decode and classify
  tpbd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .push    (push),
    .push_op (push_op)
  );

  // decoupling queue
  tpbd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_op   (head_op)
  );

  // result formatting and output register
  tpbd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .q_op    (head_op),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- rtl/tpbd_front.sv -----
// decode front: takes pattern bytes, tracks pending commands, classifies events
// depends on tpbd_pkg, tpbd_if, assert_macros.svh
`include "assert_macros.svh"

module tpbd_front
  import tpbd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  tpbd_in_if.sink      in_ch,
  input  logic         q_full,
  output logic         push,
  output tpbd_op_t     push_op
);

  typedef enum logic [1:0] {
    PEND_TEMPO      = 2'd0,
    PEND_GLIDE      = 2'd1,
    PEND_GLIDE_NOTE = 2'd2,
    PEND_NOISE      = 2'd3
  } pend_t;

  localparam logic [7:0] B_SILENCE  = 8'hE0;
  localparam logic [7:0] B_NOTE_LO  = 8'h80;
  localparam logic [7:0] B_ENV_OFF  = 8'h7F;
  localparam logic [7:0] B_ENV_LO   = 8'h71;
  localparam logic [7:0] B_ENV_BASE = 8'h70;
  localparam logic [7:0] B_ORN_LO   = 8'h60;
  localparam logic [7:0] B_SKIP_LO  = 8'h20;
  localparam logic [7:0] B_VOL_LO   = 8'h10;
  localparam logic [7:0] B_TEMPO    = 8'h0F;
  localparam logic [7:0] B_GLIDE    = 8'h0E;
  localparam logic [7:0] B_GNOTE    = 8'h0D;
  localparam logic [7:0] B_GOFF     = 8'h0C;

  logic [1:0] args_pending_r, args_pending_nxt;
  pend_t      pend_r, pend_nxt;
  logic [3:0] shape_r, shape_nxt;
  logic [7:0] lo_r, lo_nxt;
  logic [5:0] skip_r, skip_nxt;
  logic       glide_r, glide_nxt;

  logic       accept;
  logic       emit;
  logic [7:0] b;
  logic [1:0] ap;
  pend_t      pc;
  logic [3:0] shp;
  logic [7:0] lo;
  logic [5:0] skp;
  logic       gl;
  logic [7:0] skip_diff;
  logic [7:0] shape_diff;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && emit;
  assign b           = in_ch.pattern_byte;
  assign skip_diff   = b - B_SKIP_LO;
  assign shape_diff  = b - B_ENV_BASE;

  // pattern start clears state ahead of this byte
  always_comb begin
    ap  = in_ch.pattern_start ? 2'd0 : args_pending_r;
    pc  = in_ch.pattern_start ? PEND_TEMPO : pend_r;
    shp = in_ch.pattern_start ? 4'd0 : shape_r;
    lo  = in_ch.pattern_start ? 8'd0 : lo_r;
    skp = in_ch.pattern_start ? 6'd0 : skip_r;
    gl  = in_ch.pattern_start ? 1'b0 : glide_r;
  end

  // byte classification and next state
  always_comb begin
    args_pending_nxt = ap;
    pend_nxt         = pc;
    shape_nxt        = shp;
    lo_nxt           = lo;
    skip_nxt         = skp;
    glide_nxt        = gl;
    emit             = 1'b0;
    push_op.kind     = EV_SAMPLE;
    push_op.arg      = b;
    push_op.lo       = lo;
    push_op.shape    = shp;
    push_op.skip     = skp;
    push_op.glide    = gl;

    if (ap != 2'd0) begin
      // argument byte of a pending command
      if (shp != 4'd0) begin
        if (ap == 2'd2) begin
          lo_nxt           = b;
          args_pending_nxt = 2'd1;
        end else begin
          emit             = 1'b1;
          push_op.kind     = EV_ENV_SET;
          args_pending_nxt = 2'd0;
          shape_nxt        = 4'd0;
          lo_nxt           = 8'd0;
        end
      end else if (pc == PEND_GLIDE_NOTE) begin
        if (ap == 2'd3) begin
          lo_nxt     = b;
          push_op.lo = b;
        end
        args_pending_nxt = ap - 2'd1;
        if (ap == 2'd1) begin
          emit         = 1'b1;
          push_op.kind = EV_GLIDE_NOTE;
          lo_nxt       = 8'd0;
          pend_nxt     = PEND_TEMPO;
          glide_nxt    = 1'b1;
        end
      end else begin
        emit             = 1'b1;
        args_pending_nxt = 2'd0;
        pend_nxt         = PEND_TEMPO;
        unique case (pc)
          PEND_TEMPO: push_op.kind = EV_TEMPO;
          PEND_GLIDE: push_op.kind = EV_GLIDE;
          default:    push_op.kind = EV_NOISE;
        endcase
      end
    end else begin
      // command byte
      priority if (b > B_SILENCE) begin
        emit         = 1'b1;
        push_op.kind = EV_SAMPLE;
      end else if (b == B_SILENCE) begin
        emit         = 1'b1;
        push_op.kind = EV_SILENCE;
        glide_nxt    = 1'b0;
      end else if (b >= B_NOTE_LO) begin
        emit         = 1'b1;
        push_op.kind = EV_NOTE;
        glide_nxt    = 1'b0;
      end else if (b == B_ENV_OFF) begin
        emit         = 1'b1;
        push_op.kind = EV_ENV_OFF;
      end else if (b >= B_ENV_LO) begin
        shape_nxt        = shape_diff[3:0];
        args_pending_nxt = 2'd2;
      end else if (b == B_ENV_BASE) begin
        emit         = 1'b1;
        push_op.kind = EV_ROW_END;
        glide_nxt    = 1'b0;
      end else if (b >= B_ORN_LO) begin
        emit         = 1'b1;
        push_op.kind = EV_ORNAMENT;
      end else if (b >= B_SKIP_LO) begin
        skip_nxt = skip_diff[5:0];
      end else if (b >= B_VOL_LO) begin
        emit         = 1'b1;
        push_op.kind = EV_VOLUME;
      end else if (b == B_TEMPO) begin
        pend_nxt         = PEND_TEMPO;
        args_pending_nxt = 2'd1;
      end else if (b == B_GLIDE) begin
        pend_nxt         = PEND_GLIDE;
        args_pending_nxt = 2'd1;
      end else if (b == B_GNOTE) begin
        pend_nxt         = PEND_GLIDE_NOTE;
        args_pending_nxt = 2'd3;
      end else if (b == B_GOFF) begin
        emit         = 1'b1;
        push_op.kind = EV_GLIDE_OFF;
      end else begin
        pend_nxt         = PEND_NOISE;
        args_pending_nxt = 2'd1;
      end
    end
  end

  // decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      args_pending_r <= 2'd0;
      pend_r         <= PEND_TEMPO;
      shape_r        <= 4'd0;
      lo_r           <= 8'd0;
      skip_r         <= 6'd0;
      glide_r        <= 1'b0;
    end else if (accept) begin
      args_pending_r <= args_pending_nxt;
      pend_r         <= pend_nxt;
      shape_r        <= shape_nxt;
      lo_r           <= lo_nxt;
      skip_r         <= skip_nxt;
      glide_r        <= glide_nxt;
    end
  end

  `ASSERT_IMPLIES(a_env_args, shape_r != 4'd0, args_pending_r == 2'd1 || args_pending_r == 2'd2, "envelope pending without argument count")
  `ASSERT_IMPLIES(a_no_push_full, push, !q_full, "event pushed into full queue")

endmodule

// ----- rtl/tpbd_queue.sv -----
// small fifo between decode front and output back
// depends on tpbd_pkg, assert_macros.svh
`include "assert_macros.svh"

module tpbd_queue
  import tpbd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  tpbd_op_t push_op,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output tpbd_op_t head_op
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tpbd_op_t      mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head_op   = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `ASSERT_ALWAYS(a_count_range, count_r <= FULL_CNT, "queue count beyond depth")
  `ASSERT_IMPLIES(a_no_pop_empty, pop, not_empty, "pop from empty queue")

endmodule

// ----- rtl/tpbd_back.sv -----
// output back: expands queued events into result fields, holds the output register
// depends on tpbd_pkg, tpbd_if
module tpbd_back
  import tpbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  tpbd_op_t  q_op,
  output logic      pop,
  tpbd_out_if.source out_ch
);

  logic              valid_r;
  logic [3:0]        kind_r;
  logic signed [8:0] value_a_r, value_a_nxt;
  logic [15:0]       value_b_r, value_b_nxt;
  logic              row_end_r, row_end_nxt;
  logic [5:0]        empty_r;
  logic [7:0]        diff;

  assign pop = q_valid && (!valid_r || out_ch.ready);

  // field values per event kind
  always_comb begin
    value_a_nxt = '0;
    value_b_nxt = '0;
    row_end_nxt = 1'b0;
    diff        = 8'd0;
    unique case (q_op.kind)
      EV_SAMPLE: begin
        diff        = q_op.arg - 8'hE0;
        value_a_nxt = {1'b0, diff};
      end
      EV_SILENCE: row_end_nxt = 1'b1;
      EV_NOTE: begin
        diff        = q_op.arg - 8'h80;
        value_a_nxt = {1'b0, diff};
        value_b_nxt = {15'd0, q_op.glide};
        row_end_nxt = 1'b1;
      end
      EV_ENV_SET: begin
        value_a_nxt = {5'd0, q_op.shape};
        value_b_nxt = {q_op.arg, q_op.lo};
      end
      EV_ROW_END: row_end_nxt = 1'b1;
      EV_ORNAMENT: begin
        diff        = q_op.arg - 8'h60;
        value_a_nxt = {1'b0, diff};
      end
      EV_VOLUME: begin
        diff        = q_op.arg - 8'h10;
        value_a_nxt = {1'b0, diff};
      end
      EV_TEMPO:      value_a_nxt = {1'b0, q_op.arg};
      EV_GLIDE:      value_a_nxt = {q_op.arg[7], q_op.arg};
      EV_GLIDE_NOTE: value_a_nxt = {q_op.lo[7], q_op.lo};
      EV_NOISE:      value_a_nxt = {q_op.arg[7], q_op.arg};
      default: begin
        value_a_nxt = '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r    <= 4'(q_op.kind);
      value_a_r <= value_a_nxt;
      value_b_r <= value_b_nxt;
      row_end_r <= row_end_nxt;
      empty_r   <= row_end_nxt ? q_op.skip : 6'd0;
    end
  end

  assign out_ch.valid            = valid_r;
  assign out_ch.event_kind       = kind_r;
  assign out_ch.value_a          = value_a_r;
  assign out_ch.value_b          = value_b_r;
  assign out_ch.row_end          = row_end_r;
  assign out_ch.empty_rows_after = empty_r;

endmodule
